>>> rtl/tbfc_pkg.sv
// Shared types, constants and small arithmetic helpers for the triac burst-fire controller.
// Used by tbfc_span, tbfc_seq and triac_burst_fire_controller; depends on nothing else.
package tbfc_pkg;

  localparam int TICK_BITS = 16;
  localparam int ADC_BITS = 10;
  localparam int DUTY_BITS = 8;
  localparam int PCT_BITS = 7;
  localparam int PROD_BITS = TICK_BITS + PCT_BITS;
  localparam int CFG_BITS = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int BURST_PERIODS_DEF = 10;
  localparam int PCT_FULL = 100;
  localparam int ON_PER_BITS = 4;

  localparam logic [TICK_BITS-1:0] PERIOD_RST = TICK_BITS'(16383);
  localparam logic [ADC_BITS-1:0] QUIET_LOW_RST = ADC_BITS'(418);
  localparam logic [ADC_BITS-1:0] QUIET_HIGH_RST = ADC_BITS'(421);

  // floor(x/100) by reciprocal: exact while x * error < 2^shift
  localparam int DIV100_SHIFT = PROD_BITS + 7;
  localparam int DIV100_MUL_W = 2 * PROD_BITS + 1;
  localparam longint unsigned DIV100_MUL =
    ((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100;

  // floor(x/10) for x up to 100
  localparam int DIV10_SHIFT = 11;
  localparam int DIV10_MUL = 205;
  localparam int DIV10_W = PCT_BITS + 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PERIOD     = 2'd0,
    REG_QUIET_LOW  = 2'd1,
    REG_QUIET_HIGH = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_RUN  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [TICK_BITS-1:0] period_ticks;
    logic [ADC_BITS-1:0]  quiet_low;
    logic [ADC_BITS-1:0]  quiet_high;
  } cfg_t;

  // values latched by a start command
  typedef struct packed {
    logic                 burst;
    logic [TICK_BITS-1:0] period;
    logic [PROD_BITS-1:0] prod;
  } lat_t;

  typedef struct packed {
    logic [TICK_BITS-1:0] on_span;
    logic [TICK_BITS-1:0] period_len;
  } span_t;

  typedef struct packed {
    logic gate;
    logic busy;
    logic done;
  } res_t;

  function automatic logic [TICK_BITS-1:0] div100(input logic [PROD_BITS-1:0] x);
    logic [DIV100_MUL_W-1:0] p;
    p = DIV100_MUL_W'(x) * DIV100_MUL_W'(DIV100_MUL);
    return p[DIV100_SHIFT +: TICK_BITS];
  endfunction

  function automatic logic [ON_PER_BITS-1:0] div10(input logic [PCT_BITS-1:0] x);
    logic [DIV10_W-1:0] p;
    p = DIV10_W'(x) * DIV10_W'(DIV10_MUL);
    return p[DIV10_SHIFT +: ON_PER_BITS];
  endfunction

endpackage

>>> rtl/tbfc_span.sv
// Span stage: turns the latched period*duty product into on-span and period length.
// Depends on tbfc_pkg.
module tbfc_span (
  input  logic               clk,
  input  tbfc_pkg::lat_t     lat,
  output tbfc_pkg::span_t    span
);

  logic [tbfc_pkg::TICK_BITS-1:0] q_lo;
  logic [tbfc_pkg::TICK_BITS-1:0] q_hi;
  tbfc_pkg::span_t                span_next;

  // off span = period - ceil(prod/100), so length = period - ceil + floor
  always_comb begin
    q_lo = tbfc_pkg::div100(lat.prod);
    q_hi = tbfc_pkg::div100(lat.prod + tbfc_pkg::PROD_BITS'(99));
    if (lat.burst) begin
      span_next.on_span    = lat.period;
      span_next.period_len = lat.period;
    end else begin
      span_next.on_span    = q_lo;
      span_next.period_len = lat.period - q_hi + q_lo;
    end
  end

  always_ff @(posedge clk) begin
    span <= span_next;
  end

endmodule

>>> rtl/tbfc_seq.sv
// Sequencer: phase, tick and period counters and gate level, one item per step.
// Depends on tbfc_pkg; span values come from tbfc_span.
module tbfc_seq #(
  parameter int BURST_PERIODS = tbfc_pkg::BURST_PERIODS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic                            op,
  input  logic [tbfc_pkg::DUTY_BITS-1:0]  duty,
  input  logic                            full_cycle,
  input  logic [tbfc_pkg::ADC_BITS-1:0]   sample,
  input  tbfc_pkg::cfg_t                  cfg,
  input  tbfc_pkg::span_t                 span,
  output tbfc_pkg::lat_t                  lat,
  output tbfc_pkg::res_t                  res
);

  localparam int PC_BITS = $clog2(BURST_PERIODS + 1);
  localparam logic [PC_BITS-1:0] PC_LAST = PC_BITS'(BURST_PERIODS);

  tbfc_pkg::phase_t                phase, phase_next;
  logic [tbfc_pkg::TICK_BITS-1:0]  tick_count, tick_count_next;
  logic [PC_BITS-1:0]              period_count, period_count_next;
  logic [PC_BITS-1:0]              on_periods, on_periods_next;
  logic                            gate_level, gate_level_next;
  tbfc_pkg::lat_t                  lat_next;

  logic [tbfc_pkg::PCT_BITS-1:0]   pct;
  logic [tbfc_pkg::ON_PER_BITS-1:0] d10;
  logic                            leave;
  logic                            len_zero;
  logic                            first_level;
  logic [tbfc_pkg::TICK_BITS-1:0]  tc;
  logic                            wrap;
  logic [tbfc_pkg::TICK_BITS-1:0]  tick_wr;
  logic [PC_BITS-1:0]              pc_inc;
  logic                            run_level;
  logic                            done;

  always_comb begin
    pct = (duty > tbfc_pkg::DUTY_BITS'(tbfc_pkg::PCT_FULL)) ?
          tbfc_pkg::PCT_BITS'(tbfc_pkg::PCT_FULL) : duty[tbfc_pkg::PCT_BITS-1:0];
    d10 = tbfc_pkg::div10(pct);
    leave = (sample < cfg.quiet_low) || (sample > cfg.quiet_high);
    // zero-length period is known from the latched period and product alone
    len_zero = lat.burst ? (lat.period == '0) :
               ((lat.period <= tbfc_pkg::TICK_BITS'(1)) &&
                (lat.prod < tbfc_pkg::PROD_BITS'(tbfc_pkg::PCT_FULL)));
    first_level = lat.burst ? (on_periods != '0) :
                  (lat.prod >= tbfc_pkg::PROD_BITS'(tbfc_pkg::PCT_FULL));
    tc = tick_count + tbfc_pkg::TICK_BITS'(1);
    wrap = (tc == span.period_len);
    tick_wr = wrap ? '0 : tc;
    pc_inc = wrap ? period_count + PC_BITS'(1) : period_count;
    run_level = lat.burst ? (pc_inc < on_periods) : (tick_wr < span.on_span);

    phase_next = phase;
    tick_count_next = tick_count;
    period_count_next = period_count;
    on_periods_next = on_periods;
    gate_level_next = gate_level;
    lat_next = lat;
    done = 1'b0;

    if (step) begin
      if (op) begin
        phase_next = tbfc_pkg::PH_IDLE;
        tick_count_next = '0;
        period_count_next = '0;
        gate_level_next = 1'b0;
        if (pct == '0) begin
          done = 1'b1;
        end else begin
          phase_next = tbfc_pkg::PH_WAIT;
          lat_next.burst = full_cycle;
          lat_next.period = cfg.period_ticks;
          lat_next.prod = tbfc_pkg::PROD_BITS'(cfg.period_ticks) *
                          tbfc_pkg::PROD_BITS'(pct);
          if (!full_cycle) begin
            on_periods_next = '0;
          end else if (int'(d10) > BURST_PERIODS) begin
            on_periods_next = PC_LAST;
          end else begin
            on_periods_next = PC_BITS'(d10);
          end
        end
      end else begin
        case (phase)
          tbfc_pkg::PH_WAIT: begin
            if (leave) begin
              tick_count_next = '0;
              period_count_next = '0;
              if (len_zero) begin
                phase_next = tbfc_pkg::PH_IDLE;
                gate_level_next = 1'b0;
                done = 1'b1;
              end else begin
                phase_next = tbfc_pkg::PH_RUN;
                gate_level_next = first_level;
              end
            end
          end
          tbfc_pkg::PH_RUN: begin
            if (pc_inc >= PC_LAST) begin
              phase_next = tbfc_pkg::PH_IDLE;
              tick_count_next = '0;
              period_count_next = '0;
              gate_level_next = 1'b0;
              done = 1'b1;
            end else begin
              tick_count_next = tick_wr;
              period_count_next = pc_inc;
              gate_level_next = run_level;
            end
          end
          tbfc_pkg::PH_IDLE: begin
            gate_level_next = 1'b0;
          end
          default: begin
            phase_next = tbfc_pkg::PH_IDLE;
            gate_level_next = 1'b0;
          end
        endcase
      end
    end

    res.gate = gate_level_next;
    res.busy = (phase_next != tbfc_pkg::PH_IDLE);
    res.done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tbfc_pkg::PH_IDLE;
      tick_count <= '0;
      period_count <= '0;
      on_periods <= '0;
      gate_level <= 1'b0;
    end else begin
      phase <= phase_next;
      tick_count <= tick_count_next;
      period_count <= period_count_next;
      on_periods <= on_periods_next;
      gate_level <= gate_level_next;
    end
  end

  always_ff @(posedge clk) begin
    lat <= lat_next;
  end

  a_gate_only_run: assert property (@(posedge clk) disable iff (rst)
    gate_level |-> phase == tbfc_pkg::PH_RUN)
    else $error("gate high outside a running sequence");

  a_period_bound: assert property (@(posedge clk) disable iff (rst)
    phase == tbfc_pkg::PH_RUN |-> period_count < PC_LAST)
    else $error("period count beyond burst length");

  // span stage must have caught up by the first running tick
  a_tick_in_span: assert property (@(posedge clk) disable iff (rst)
    phase == tbfc_pkg::PH_RUN |-> tick_count < span.period_len)
    else $error("tick count outside period length");

endmodule

>>> rtl/triac_burst_fire_controller.sv
// Triac burst-fire controller, top level: config registers, input and result registers.
// Depends on tbfc_pkg, tbfc_span and tbfc_seq.
//
// One item (a microsecond tick or a start command) can be taken every clock; its result
// passes the input register into the result register once that register is free,
// and in_ready follows out_ready through that two-deep pipe. A start latches
// period*duty in one multiplier; the span stage registers on-span and period length
// from that product, in time for the first running tick. Config is taken at once on cfg_we.
module triac_burst_fire_controller #(
  parameter int BURST_PERIODS = tbfc_pkg::BURST_PERIODS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic [tbfc_pkg::DUTY_BITS-1:0]     duty,
  input  logic                               full_cycle,
  input  logic [tbfc_pkg::ADC_BITS-1:0]      sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               gate,
  output logic                               busy_res,
  output logic                               done_res,
  input  logic                               cfg_we,
  input  logic [tbfc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tbfc_pkg::CFG_BITS-1:0]      cfg_data
);

  tbfc_pkg::cfg_t                  cfg;
  logic                            iv;
  logic                            i_op;
  logic [tbfc_pkg::DUTY_BITS-1:0]  i_duty;
  logic                            i_full;
  logic [tbfc_pkg::ADC_BITS-1:0]   i_sample;
  logic                            step;
  tbfc_pkg::lat_t                  lat;
  tbfc_pkg::span_t                 span;
  tbfc_pkg::res_t                  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks <= tbfc_pkg::PERIOD_RST;
      cfg.quiet_low <= tbfc_pkg::QUIET_LOW_RST;
      cfg.quiet_high <= tbfc_pkg::QUIET_HIGH_RST;
    end else if (cfg_we) begin
      case (tbfc_pkg::cfg_reg_t'(cfg_index))
        tbfc_pkg::REG_PERIOD: begin
          cfg.period_ticks <= cfg_data[tbfc_pkg::TICK_BITS-1:0];
        end
        tbfc_pkg::REG_QUIET_LOW: begin
          cfg.quiet_low <= cfg_data[tbfc_pkg::ADC_BITS-1:0];
        end
        tbfc_pkg::REG_QUIET_HIGH: begin
          cfg.quiet_high <= cfg_data[tbfc_pkg::ADC_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign step = iv && (!out_valid || out_ready);
  assign in_ready = !iv || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_ready) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      i_op <= op;
      i_duty <= duty;
      i_full <= full_cycle;
      i_sample <= sample;
    end
  end

  tbfc_seq #(
    .BURST_PERIODS(BURST_PERIODS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .op         (i_op),
    .duty       (i_duty),
    .full_cycle (i_full),
    .sample     (i_sample),
    .cfg        (cfg),
    .span       (span),
    .lat        (lat),
    .res        (res)
  );

  tbfc_span u_span (
    .clk  (clk),
    .lat  (lat),
    .span (span)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      gate <= res.gate;
      busy_res <= res.busy;
      done_res <= res.done;
    end
  end

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !gate)
    else $error("done item still busy or gate high");

endmodule

>>> tb/tb_triac_burst_fire_controller.sv
// Testbench for triac_burst_fire_controller: a directed table followed by random firing
// sequences, each checked against its typed row or a cycle-free burst/dimmer predictor.
// Depends on tbfc_pkg and the controller RTL only.
module tb_triac_burst_fire_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_PERIODS = tbfc_pkg::BURST_PERIODS_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int N_DIR = 30;
  localparam int PHASE_ITEMS = 210;
  localparam int N_PHASES = 8;
  localparam logic [tbfc_pkg::ADC_BITS-1:0] ADC_TOP = '1;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_START,
    ROW_REG
  } row_kind_t;

  // ROW_REG: arg = register, val = data. Otherwise val = duty.
  typedef struct {
    row_kind_t                       kind;
    int unsigned                     arg;
    int unsigned                     val;
    logic                            full;
    logic [tbfc_pkg::ADC_BITS-1:0]   sample;
    logic                            typed;
    logic [2:0]                      exp;
  } dir_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              op = 1'b0;
  logic [tbfc_pkg::DUTY_BITS-1:0]    duty = '0;
  logic                              full_cycle = 1'b0;
  logic [tbfc_pkg::ADC_BITS-1:0]     sample = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              gate;
  logic                              busy_res;
  logic                              done_res;
  logic                              cfg_we = 1'b0;
  logic [tbfc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [tbfc_pkg::CFG_BITS-1:0]     cfg_data = '0;

  triac_burst_fire_controller dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .duty(duty),
    .full_cycle(full_cycle),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .gate(gate),
    .busy_res(busy_res),
    .done_res(done_res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state and its copy of the registers
  logic [tbfc_pkg::TICK_BITS-1:0] m_period = tbfc_pkg::PERIOD_RST;
  logic [tbfc_pkg::ADC_BITS-1:0]  m_qlo = tbfc_pkg::QUIET_LOW_RST;
  logic [tbfc_pkg::ADC_BITS-1:0]  m_qhi = tbfc_pkg::QUIET_HIGH_RST;
  tbfc_pkg::phase_t               m_phase = tbfc_pkg::PH_IDLE;
  int unsigned                    m_ticks = 0;
  int unsigned                    m_pcount = 0;
  logic                           m_burst = 1'b0;
  int unsigned                    m_on = 0;
  int unsigned                    m_off = 0;
  int unsigned                    m_on_per = 0;
  logic                           m_gate = 1'b0;

  tbfc_pkg::res_t fire_q[$];
  int unsigned    n_err = 0;
  int unsigned    n_sent = 0;
  int unsigned    burst_left = 0;
  int unsigned    idle_cycles = 0;
  logic           held_long = 1'b0;

  dir_row_t dir_tab [N_DIR] = '{
    '{ROW_TICK,  0, 0,   1'b0, 10'd0,    1'b1, 3'b000},
    '{ROW_TICK,  0, 255, 1'b1, 10'd1023, 1'b1, 3'b000},
    '{ROW_START, 0, 0,   1'b0, 10'd0,    1'b1, 3'b001},
    '{ROW_START, 0, 255, 1'b1, 10'd1023, 1'b1, 3'b010},
    '{ROW_TICK,  0, 0,   1'b0, 10'd418,  1'b1, 3'b010},
    '{ROW_TICK,  0, 0,   1'b0, 10'd421,  1'b1, 3'b010},
    '{ROW_TICK,  0, 0,   1'b0, 10'd417,  1'b1, 3'b110},
    '{ROW_TICK,  0, 0,   1'b0, 10'd0,    1'b1, 3'b110},
    '{ROW_START, 0, 37,  1'b0, 10'd512,  1'b1, 3'b010},
    '{ROW_TICK,  0, 0,   1'b0, 10'd422,  1'b0, 3'b000},
    '{ROW_TICK,  0, 0,   1'b0, 10'd700,  1'b0, 3'b000},
    '{ROW_START, 0, 0,   1'b0, 10'd0,    1'b1, 3'b001},
    '{ROW_REG,   int'(tbfc_pkg::REG_PERIOD), 0, 1'b0, 10'd0, 1'b0, 3'b000},
    '{ROW_START, 0, 100, 1'b1, 10'd0,    1'b1, 3'b010},
    '{ROW_TICK,  0, 0,   1'b0, 10'd1023, 1'b1, 3'b001},
    '{ROW_REG,   int'(tbfc_pkg::REG_PERIOD), 1, 1'b0, 10'd0, 1'b0, 3'b000},
    '{ROW_START, 0, 50,  1'b0, 10'd0,    1'b1, 3'b010},
    '{ROW_TICK,  0, 0,   1'b0, 10'd0,    1'b1, 3'b001},
    '{ROW_REG,   int'(tbfc_pkg::REG_QUIET_LOW), 0, 1'b0, 10'd0, 1'b0, 3'b000},
    '{ROW_REG,   int'(tbfc_pkg::REG_QUIET_HIGH), 1023, 1'b0, 10'd0, 1'b0, 3'b000},
    '{ROW_START, 0, 1,   1'b0, 10'd0,    1'b1, 3'b010},
    '{ROW_TICK,  0, 0,   1'b0, 10'd0,    1'b1, 3'b010},
    '{ROW_TICK,  0, 0,   1'b0, 10'd1023, 1'b1, 3'b010},
    '{ROW_REG,   int'(tbfc_pkg::REG_PERIOD), 65535, 1'b0, 10'd0, 1'b0, 3'b000},
    '{ROW_REG,   int'(tbfc_pkg::REG_QUIET_LOW), 5, 1'b0, 10'd0, 1'b0, 3'b000},
    '{ROW_REG,   int'(tbfc_pkg::REG_QUIET_HIGH), 4, 1'b0, 10'd0, 1'b0, 3'b000},
    '{ROW_START, 0, 100, 1'b0, 10'd0,    1'b0, 3'b000},
    '{ROW_TICK,  0, 0,   1'b0, 10'd4,    1'b0, 3'b000},
    '{ROW_TICK,  0, 0,   1'b0, 10'd4,    1'b0, 3'b000},
    '{ROW_START, 0, 0,   1'b0, 10'd0,    1'b1, 3'b001}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic gate_level_now();
    if (m_burst)
      return m_pcount < m_on_per;
    return m_ticks < m_on;
  endfunction

  // one item through the burst/dimmer sequencer
  function automatic tbfc_pkg::res_t fire_model(input logic o,
                                                input logic [tbfc_pkg::DUTY_BITS-1:0] d,
                                                input logic f,
                                                input logic [tbfc_pkg::ADC_BITS-1:0] s);
    int unsigned    pct;
    int unsigned    plen;
    logic           fin;
    tbfc_pkg::res_t r;
    fin = 1'b0;
    plen = m_on + m_off;
    if (o) begin
      pct = (d > tbfc_pkg::PCT_FULL) ? tbfc_pkg::PCT_FULL : d;
      m_phase = tbfc_pkg::PH_IDLE;
      m_gate = 1'b0;
      m_ticks = 0;
      m_pcount = 0;
      if (pct == 0) begin
        fin = 1'b1;
      end else begin
        m_burst = f;
        if (f) begin
          m_on = m_period;
          m_off = 0;
          m_on_per = pct / 10;
        end else begin
          m_on = (m_period * pct) / 100;
          m_off = (m_period * (100 - pct)) / 100;
          m_on_per = 0;
        end
        m_phase = tbfc_pkg::PH_WAIT;
      end
    end else if (m_phase == tbfc_pkg::PH_WAIT) begin
      if (s < m_qlo || s > m_qhi) begin
        m_ticks = 0;
        m_pcount = 0;
        if (plen == 0) begin
          m_phase = tbfc_pkg::PH_IDLE;
          m_gate = 1'b0;
          fin = 1'b1;
        end else begin
          m_phase = tbfc_pkg::PH_RUN;
          m_gate = gate_level_now();
        end
      end
    end else if (m_phase == tbfc_pkg::PH_RUN) begin
      m_ticks++;
      if (m_ticks >= plen) begin
        m_ticks = 0;
        m_pcount++;
      end
      if (m_pcount >= N_PERIODS) begin
        m_phase = tbfc_pkg::PH_IDLE;
        m_gate = 1'b0;
        m_ticks = 0;
        m_pcount = 0;
        fin = 1'b1;
      end else begin
        m_gate = gate_level_now();
      end
    end else begin
      m_gate = 1'b0;
    end
    r.gate = m_gate;
    r.busy = (m_phase != tbfc_pkg::PH_IDLE);
    r.done = fin;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    n_err++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic send_item(input logic o, input logic [tbfc_pkg::DUTY_BITS-1:0] d,
                           input logic f, input logic [tbfc_pkg::ADC_BITS-1:0] s,
                           input logic typed, input tbfc_pkg::res_t typed_exp);
    int unsigned    gap;
    tbfc_pkg::res_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    op <= o;
    duty <= d;
    full_cycle <= f;
    sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    r = fire_model(o, d, f, s);
    fire_q.push_back(typed ? typed_exp : r);
    n_sent++;
  endtask

  task automatic send_tick(input logic [tbfc_pkg::ADC_BITS-1:0] s);
    send_item(1'b0, tbfc_pkg::DUTY_BITS'($urandom), 1'($urandom), s, 1'b0, '0);
  endtask

  // registers only change with the pipe empty
  task automatic write_reg(input tbfc_pkg::cfg_reg_t idx, input int unsigned val);
    in_valid <= 1'b0;
    burst_left = 0;
    while (fire_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= tbfc_pkg::CFG_BITS'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tbfc_pkg::REG_PERIOD:     m_period = tbfc_pkg::TICK_BITS'(val);
      tbfc_pkg::REG_QUIET_LOW:  m_qlo = tbfc_pkg::ADC_BITS'(val);
      tbfc_pkg::REG_QUIET_HIGH: m_qhi = tbfc_pkg::ADC_BITS'(val);
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    tbfc_pkg::res_t e;
    if (!rst && out_valid && out_ready) begin
      if (fire_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: gate %0b busy %0b done %0b",
                                  gate, busy_res, done_res));
      end else begin
        e = fire_q.pop_front();
        if (gate !== e.gate)
          report_mismatch($sformatf("gate %0b, expected %0b", gate, e.gate));
        if (busy_res !== e.busy)
          report_mismatch($sformatf("busy_res %0b, expected %0b", busy_res, e.busy));
        if (done_res !== e.done)
          report_mismatch($sformatf("done_res %0b, expected %0b", done_res, e.done));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL triac_burst_fire_controller");
      $finish;
    end
  end

  // receiver: changing stall patterns, plus one long hold-off to back the pipe up
  initial begin
    int unsigned rx_mode;
    int unsigned rx_left;
    int unsigned rx_per;
    rx_mode = 0;
    rx_left = 0;
    rx_per = 2;
    forever begin
      @(posedge clk);
      if (!held_long && n_sent > 700) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
        rx_per = $urandom_range(2, 9);
      end
      rx_left--;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= (rx_left % rx_per) != 0;
      endcase
    end
  end

  initial begin
    dir_row_t                      row;
    int unsigned                   pct;
    int unsigned                   n_phase;
    int unsigned                   run_len;
    int unsigned                   n_run;
    int unsigned                   lo;
    logic [tbfc_pkg::ADC_BITS-1:0] s;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      row = dir_tab[i];
      case (row.kind)
        ROW_REG:   write_reg(tbfc_pkg::cfg_reg_t'(row.arg), row.val);
        ROW_START: send_item(1'b1, tbfc_pkg::DUTY_BITS'(row.val), row.full, row.sample,
                             row.typed, tbfc_pkg::res_t'(row.exp));
        default:   send_item(1'b0, tbfc_pkg::DUTY_BITS'(row.val), row.full, row.sample,
                             row.typed, tbfc_pkg::res_t'(row.exp));
      endcase
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       write_reg(tbfc_pkg::REG_PERIOD, 2);
        1:       write_reg(tbfc_pkg::REG_PERIOD, 0);
        3:       write_reg(tbfc_pkg::REG_PERIOD, 65535);
        4:       write_reg(tbfc_pkg::REG_PERIOD, 1);
        default: write_reg(tbfc_pkg::REG_PERIOD, $urandom_range(1, 12));
      endcase
      case (ph)
        5: begin
          lo = $urandom_range(1, 1023);
          write_reg(tbfc_pkg::REG_QUIET_LOW, lo);
          write_reg(tbfc_pkg::REG_QUIET_HIGH, $urandom_range(0, lo - 1));
        end
        6: begin
          write_reg(tbfc_pkg::REG_QUIET_LOW, 0);
          write_reg(tbfc_pkg::REG_QUIET_HIGH, $urandom_range(0, 6));
        end
        7: begin
          write_reg(tbfc_pkg::REG_QUIET_LOW, $urandom_range(1015, 1023));
          write_reg(tbfc_pkg::REG_QUIET_HIGH, 1023);
        end
        default: begin
          lo = $urandom_range(0, 1015);
          write_reg(tbfc_pkg::REG_QUIET_LOW, lo);
          write_reg(tbfc_pkg::REG_QUIET_HIGH, lo + $urandom_range(0, 8));
        end
      endcase

      n_phase = n_sent + PHASE_ITEMS;
      while (n_sent < n_phase) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: anything at all
          send_item(($urandom_range(0, 3) == 0), tbfc_pkg::DUTY_BITS'($urandom),
                    1'($urandom), tbfc_pkg::ADC_BITS'($urandom), 1'b0, '0);
        end else begin
          case ($urandom_range(0, 9))
            0:       pct = 0;
            1:       pct = $urandom_range(101, 255);
            default: pct = $urandom_range(1, 100);
          endcase
          send_item(1'b1, tbfc_pkg::DUTY_BITS'(pct), 1'($urandom),
                    tbfc_pkg::ADC_BITS'($urandom), 1'b0, '0);
          // a few ticks inside the quiet band
          repeat ($urandom_range(0, 3)) begin
            if (m_qlo <= m_qhi)
              s = tbfc_pkg::ADC_BITS'($urandom_range(m_qhi, m_qlo));
            else
              s = tbfc_pkg::ADC_BITS'($urandom);
            send_tick(s);
          end
          // the tick that leaves the band
          if (m_qlo > m_qhi)
            s = tbfc_pkg::ADC_BITS'($urandom);
          else if (m_qlo > 0 && (m_qhi == ADC_TOP || $urandom_range(0, 1) == 1))
            s = tbfc_pkg::ADC_BITS'($urandom_range(0, m_qlo - 1));
          else if (m_qhi < ADC_TOP)
            s = tbfc_pkg::ADC_BITS'($urandom_range(m_qhi + 1, ADC_TOP));
          else
            s = tbfc_pkg::ADC_BITS'($urandom);
          send_tick(s);
          // run to the end, or break off early for a restart
          run_len = N_PERIODS * (m_on + m_off);
          if (run_len <= 300 && $urandom_range(0, 7) != 0)
            n_run = run_len + $urandom_range(0, 2);
          else
            n_run = $urandom_range(0, (run_len < 40) ? run_len : 40);
          repeat (n_run) send_tick(tbfc_pkg::ADC_BITS'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    while (fire_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_err == 0 && fire_q.size() == 0) begin
      $display("PASS triac_burst_fire_controller");
    end else begin
      $display("FAIL triac_burst_fire_controller");
    end
    $finish;
  end

endmodule
